### hdl/owbm_pkg.sv
// Shared types and constants for the single-wire bus master.
// No dependencies; used by owbm_cfg and onewire_bus_master.
`default_nettype none

package owbm_pkg;

    // tick counter width and its saturation value
    localparam int TICK_COUNT_WIDTH = 10;
    localparam logic [TICK_COUNT_WIDTH-1:0] CNT_MAX = {TICK_COUNT_WIDTH{1'b1}};

    // timing registers
    localparam int CFG_W     = 10;
    localparam int CFG_NUM   = 8;
    localparam int CFG_IDX_W = $clog2(CFG_NUM);

    // width used to compare the counter against a phase length
    localparam int CMP_W = (TICK_COUNT_WIDTH > CFG_W) ? TICK_COUNT_WIDTH : CFG_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_WAIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_REC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_HOLD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_REC    = 3'd7;

    typedef logic [CFG_NUM-1:0][CFG_W-1:0] t_cfg_regs;

    // register values after reset
    localparam t_cfg_regs CFG_RESET_VALS = {
        10'd50, 10'd5, 10'd5, 10'd55, 10'd10, 10'd500, 10'd70, 10'd500
    };

    // request kinds
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_RESET = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_REC  = 4'd3,
        PH_WR_LOW   = 4'd4,
        PH_WR_HOLD  = 4'd5,
        PH_RD_LOW   = 4'd6,
        PH_RD_WAIT  = 4'd7,
        PH_RD_REC   = 4'd8
    } t_phase;

    // bus widths
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

endpackage

`default_nettype wire

### hdl/owbm_cfg.sv
// Timing register file of the single-wire bus master.
// Depends on owbm_pkg.
`default_nettype none

module owbm_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [owbm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [owbm_pkg::CFG_W-1:0]     i_cfg_data,
    output owbm_pkg::t_cfg_regs                o_cfg
);

    owbm_pkg::t_cfg_regs r_cfg;

    // register write, reset to the nominal bus timings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= owbm_pkg::CFG_RESET_VALS;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### hdl/onewire_bus_master.sv
// Single-wire bus master: one tick per transfer, one result per tick.
// Depends on owbm_pkg and owbm_cfg.
//
//  channel   | dir | signals                        | payload
//  ----------+-----+--------------------------------+--------------------------------
//  s_axis    | in  | tvalid tready tdata tuser      | tuser: req_type; tdata: tx_byte, line_in
//  m_axis    | out | tvalid tready tdata            | line_release busy done presence rx_byte
//  cfg       | in  | i_cfg_we i_cfg_idx i_cfg_data  | timing register write
//
// The phase sequencer and the output register both load at the accepting edge, so the
// result is offered in the following cycle. One tick per cycle is sustained; the single
// output register sets the pace and s_axis_tready drops only while that register is full
// and m_axis is stalled.
// Synchronous active-low reset returns to idle with the nominal timings loaded.
`default_nettype none

module onewire_bus_master (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input ticks
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [owbm_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [7:0] tx_byte, [8] line_in
    input  wire logic [owbm_pkg::IN_USER_W-1:0]    s_axis_tuser,  // [1:0] req_type
    // results
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [owbm_pkg::OUT_DATA_W-1:0]        m_axis_tdata,  // [0] line_release, [1] busy_res,
                                                                  // [2] done_res, [3] presence_level,
                                                                  // [11:4] rx_byte
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [owbm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [owbm_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int TCW = owbm_pkg::TICK_COUNT_WIDTH;
    localparam int CMW = owbm_pkg::CMP_W;

    owbm_pkg::t_cfg_regs cfg;

    owbm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // sequencer state
    owbm_pkg::t_phase r_phase, n_phase;
    logic [TCW-1:0]   r_cnt, n_cnt;
    logic [2:0]       r_bit, n_bit;
    logic [7:0]       r_shift, n_shift;
    logic             r_presence, n_presence;
    logic [7:0]       r_rx, n_rx;

    // output register
    logic                           r_out_valid;
    logic [owbm_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic               accept;
    owbm_pkg::t_req     req;
    logic [7:0]         tx_byte;
    logic               line_in;
    owbm_pkg::t_phase   ph0;
    logic [TCW-1:0]     cnt0, cnt_inc;
    logic [2:0]         bit0;
    logic [7:0]         shift0;
    logic [owbm_pkg::CFG_W-1:0] len;
    logic               ph_end, drive, busy, done;

    assign req     = owbm_pkg::t_req'(s_axis_tuser);
    assign tx_byte = s_axis_tdata[7:0];
    assign line_in = s_axis_tdata[8];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // start of an operation when idle
    always_comb begin
        ph0    = r_phase;
        cnt0   = r_cnt;
        bit0   = r_bit;
        shift0 = r_shift;
        if (r_phase == owbm_pkg::PH_IDLE && req != owbm_pkg::REQ_TICK) begin
            cnt0 = '0;
            bit0 = '0;
            case (req)
                owbm_pkg::REQ_RESET: ph0 = owbm_pkg::PH_RST_LOW;
                owbm_pkg::REQ_WRITE: begin
                    ph0    = owbm_pkg::PH_WR_LOW;
                    shift0 = tx_byte;
                end
                default: begin
                    ph0    = owbm_pkg::PH_RD_LOW;
                    shift0 = '0;
                end
            endcase
        end
    end

    // phase length select
    always_comb begin
        case (ph0)
            owbm_pkg::PH_RST_LOW:  len = cfg[owbm_pkg::CFG_RESET_LOW];
            owbm_pkg::PH_RST_WAIT: len = cfg[owbm_pkg::CFG_PRES_WAIT];
            owbm_pkg::PH_RST_REC:  len = cfg[owbm_pkg::CFG_RESET_REC];
            owbm_pkg::PH_WR_LOW:   len = cfg[owbm_pkg::CFG_WRITE_LOW];
            owbm_pkg::PH_WR_HOLD:  len = cfg[owbm_pkg::CFG_WRITE_HOLD];
            owbm_pkg::PH_RD_LOW:   len = cfg[owbm_pkg::CFG_READ_LOW];
            owbm_pkg::PH_RD_WAIT:  len = cfg[owbm_pkg::CFG_READ_SAMPLE];
            owbm_pkg::PH_RD_REC:   len = cfg[owbm_pkg::CFG_READ_REC];
            default:               len = '0;
        endcase
    end

    // saturating tick count and end of phase
    assign cnt_inc = (cnt0 == owbm_pkg::CNT_MAX) ? cnt0 : cnt0 + 1'b1;
    assign ph_end  = (CMW'(cnt_inc) >= CMW'(len)) || (cnt_inc == owbm_pkg::CNT_MAX);

    // next state and line drive
    always_comb begin
        n_phase    = ph0;
        n_cnt      = cnt0;
        n_bit      = bit0;
        n_shift    = shift0;
        n_presence = r_presence;
        n_rx       = r_rx;
        drive      = 1'b1;
        busy       = 1'b0;
        done       = 1'b0;
        if (ph0 != owbm_pkg::PH_IDLE) begin
            busy  = 1'b1;
            n_cnt = cnt_inc;
            case (ph0)
                owbm_pkg::PH_RST_LOW,
                owbm_pkg::PH_WR_LOW,
                owbm_pkg::PH_RD_LOW:   drive = 1'b0;
                owbm_pkg::PH_WR_HOLD:  drive = shift0[bit0];
                default:               drive = 1'b1;
            endcase
            if (ph_end) begin
                n_cnt = '0;
                case (ph0)
                    owbm_pkg::PH_RST_LOW:  n_phase = owbm_pkg::PH_RST_WAIT;
                    owbm_pkg::PH_RST_WAIT: begin
                        n_presence = line_in;
                        n_phase    = owbm_pkg::PH_RST_REC;
                    end
                    owbm_pkg::PH_RST_REC: begin
                        n_phase = owbm_pkg::PH_IDLE;
                        done    = 1'b1;
                    end
                    owbm_pkg::PH_WR_LOW:   n_phase = owbm_pkg::PH_WR_HOLD;
                    owbm_pkg::PH_WR_HOLD: begin
                        if (bit0 == 3'd7) begin
                            n_phase = owbm_pkg::PH_IDLE;
                            done    = 1'b1;
                        end else begin
                            n_bit   = bit0 + 3'd1;
                            n_phase = owbm_pkg::PH_WR_LOW;
                        end
                    end
                    owbm_pkg::PH_RD_LOW:   n_phase = owbm_pkg::PH_RD_WAIT;
                    owbm_pkg::PH_RD_WAIT: begin
                        n_shift[bit0] = shift0[bit0] | line_in;
                        n_phase       = owbm_pkg::PH_RD_REC;
                    end
                    owbm_pkg::PH_RD_REC: begin
                        if (bit0 == 3'd7) begin
                            n_rx    = shift0;
                            n_phase = owbm_pkg::PH_IDLE;
                            done    = 1'b1;
                        end else begin
                            n_bit   = bit0 + 3'd1;
                            n_phase = owbm_pkg::PH_RD_LOW;
                        end
                    end
                    default:               n_phase = owbm_pkg::PH_IDLE;
                endcase
            end
        end
    end

    // result packing
    assign n_out_data = {4'b0000, n_rx, n_presence, done, busy, drive};

    // sequencer registers advance once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= owbm_pkg::PH_IDLE;
            r_cnt      <= '0;
            r_bit      <= '0;
            r_shift    <= '0;
            r_presence <= 1'b1;
            r_rx       <= '0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_presence <= n_presence;
            r_rx       <= n_rx;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // a completion tick is always a busy tick
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[2] |-> r_out_data[1])
        else $error("done without busy");

    // completion returns the sequencer to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && done |=> r_phase == owbm_pkg::PH_IDLE)
        else $error("not idle after done");

    // counter is clear whenever the sequencer idles
    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == owbm_pkg::PH_IDLE |-> r_cnt == '0)
        else $error("tick count left over in idle");

    // an empty output register never blocks input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with empty output");
`endif

endmodule

`default_nettype wire

### tb/tb_onewire_bus_master.sv
`timescale 1ns / 100ps
// Self-checking testbench for onewire_bus_master: line sequencing, presence and read bytes.
// Depends on owbm_pkg; carries its own tick-level model of the bus master.

module tb_onewire_bus_master;

    localparam int PHASE_COUNT  = 16;
    localparam int PHASE_TICKS  = 25;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 10;
    localparam int LEN_LONG     = 12;

    typedef logic [owbm_pkg::CFG_W-1:0] t_timing_set [owbm_pkg::CFG_NUM];

    // expected content of one result transfer
    typedef struct {
        logic       line_release;
        logic       busy_res;
        logic       done_res;
        logic       presence_level;
        logic [7:0] rx_byte;
    } t_line_result;

    // Tick-level model of the bus master plus the queue of results it predicts
    class onewire_line_model;
        logic [owbm_pkg::CFG_W-1:0]            timing [owbm_pkg::CFG_NUM];
        owbm_pkg::t_phase                      phase;
        logic [owbm_pkg::TICK_COUNT_WIDTH-1:0] ticks;
        logic [2:0]                            bit_idx;
        logic [7:0]                            shift_byte;
        logic                                  presence;
        logic [7:0]                            rx_held;
        t_line_result                          expected_ticks [$];
        int                                    errors;

        function new();
            timing[owbm_pkg::CFG_RESET_LOW]   = 10'd500;
            timing[owbm_pkg::CFG_PRES_WAIT]   = 10'd70;
            timing[owbm_pkg::CFG_RESET_REC]   = 10'd500;
            timing[owbm_pkg::CFG_WRITE_LOW]   = 10'd10;
            timing[owbm_pkg::CFG_WRITE_HOLD]  = 10'd55;
            timing[owbm_pkg::CFG_READ_LOW]    = 10'd5;
            timing[owbm_pkg::CFG_READ_SAMPLE] = 10'd5;
            timing[owbm_pkg::CFG_READ_REC]    = 10'd50;
            phase      = owbm_pkg::PH_IDLE;
            ticks      = '0;
            bit_idx    = '0;
            shift_byte = '0;
            presence   = 1'b1;
            rx_held    = '0;
            errors     = 0;
        endfunction

        function void set_timing(int idx, logic [owbm_pkg::CFG_W-1:0] val);
            timing[idx] = val;
        endfunction

        function bit in_operation();
            return phase != owbm_pkg::PH_IDLE;
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        // length register that governs the current phase
        function logic [owbm_pkg::CFG_W-1:0] phase_len();
            case (phase)
                owbm_pkg::PH_RST_LOW:  return timing[owbm_pkg::CFG_RESET_LOW];
                owbm_pkg::PH_RST_WAIT: return timing[owbm_pkg::CFG_PRES_WAIT];
                owbm_pkg::PH_RST_REC:  return timing[owbm_pkg::CFG_RESET_REC];
                owbm_pkg::PH_WR_LOW:   return timing[owbm_pkg::CFG_WRITE_LOW];
                owbm_pkg::PH_WR_HOLD:  return timing[owbm_pkg::CFG_WRITE_HOLD];
                owbm_pkg::PH_RD_LOW:   return timing[owbm_pkg::CFG_READ_LOW];
                owbm_pkg::PH_RD_WAIT:  return timing[owbm_pkg::CFG_READ_SAMPLE];
                default:               return timing[owbm_pkg::CFG_READ_REC];
            endcase
        endfunction

        // advance one tick and queue the result it produces
        function void take_tick(owbm_pkg::t_req req, logic [7:0] txb, logic lin);
            t_line_result r;
            bit           stop;
            r.line_release = 1'b1;
            r.busy_res     = 1'b0;
            r.done_res     = 1'b0;

            // a request only starts from idle, on this same tick
            if (phase == owbm_pkg::PH_IDLE && req != owbm_pkg::REQ_TICK) begin
                ticks   = '0;
                bit_idx = '0;
                case (req)
                    owbm_pkg::REQ_RESET: phase = owbm_pkg::PH_RST_LOW;
                    owbm_pkg::REQ_WRITE: begin
                        phase      = owbm_pkg::PH_WR_LOW;
                        shift_byte = txb;
                    end
                    default: begin
                        phase      = owbm_pkg::PH_RD_LOW;
                        shift_byte = '0;
                    end
                endcase
            end

            if (phase != owbm_pkg::PH_IDLE) begin
                r.busy_res = 1'b1;
                case (phase)
                    owbm_pkg::PH_RST_LOW, owbm_pkg::PH_WR_LOW, owbm_pkg::PH_RD_LOW:
                        r.line_release = 1'b0;
                    owbm_pkg::PH_WR_HOLD: r.line_release = shift_byte[bit_idx];
                    default:              r.line_release = 1'b1;
                endcase

                // counter saturates; a zero length ends after one tick
                if (ticks < owbm_pkg::CNT_MAX)
                    ticks = ticks + 1'b1;
                stop = (int'(ticks) >= int'(phase_len())) || (ticks == owbm_pkg::CNT_MAX);

                if (stop) begin
                    ticks = '0;
                    case (phase)
                        owbm_pkg::PH_RST_LOW:  phase = owbm_pkg::PH_RST_WAIT;
                        owbm_pkg::PH_RST_WAIT: begin
                            presence = lin;
                            phase    = owbm_pkg::PH_RST_REC;
                        end
                        owbm_pkg::PH_RST_REC: begin
                            phase      = owbm_pkg::PH_IDLE;
                            r.done_res = 1'b1;
                        end
                        owbm_pkg::PH_WR_LOW:   phase = owbm_pkg::PH_WR_HOLD;
                        owbm_pkg::PH_WR_HOLD: begin
                            if (bit_idx == 3'd7) begin
                                phase      = owbm_pkg::PH_IDLE;
                                r.done_res = 1'b1;
                            end else begin
                                bit_idx = bit_idx + 1'b1;
                                phase   = owbm_pkg::PH_WR_LOW;
                            end
                        end
                        owbm_pkg::PH_RD_LOW:   phase = owbm_pkg::PH_RD_WAIT;
                        owbm_pkg::PH_RD_WAIT: begin
                            if (lin)
                                shift_byte[bit_idx] = 1'b1;
                            phase = owbm_pkg::PH_RD_REC;
                        end
                        owbm_pkg::PH_RD_REC: begin
                            if (bit_idx == 3'd7) begin
                                rx_held    = shift_byte;
                                phase      = owbm_pkg::PH_IDLE;
                                r.done_res = 1'b1;
                            end else begin
                                bit_idx = bit_idx + 1'b1;
                                phase   = owbm_pkg::PH_RD_LOW;
                            end
                        end
                        default: phase = owbm_pkg::PH_IDLE;
                    endcase
                end
            end

            r.presence_level = presence;
            r.rx_byte        = rx_held;
            expected_ticks.push_back(r);
        endfunction

        // compare one result transfer against the oldest prediction
        function void check_result(logic [owbm_pkg::OUT_DATA_W-1:0] d);
            t_line_result want;
            if (expected_ticks.size() == 0) begin
                $error("result transfer with no tick waiting: tdata %h", d);
                errors++;
                return;
            end
            want = expected_ticks.pop_front();
            if (d[0] !== want.line_release) begin
                $error("line_release: expected %0b, actual %0b", want.line_release, d[0]);
                errors++;
            end
            if (d[1] !== want.busy_res) begin
                $error("busy_res: expected %0b, actual %0b", want.busy_res, d[1]);
                errors++;
            end
            if (d[2] !== want.done_res) begin
                $error("done_res: expected %0b, actual %0b", want.done_res, d[2]);
                errors++;
            end
            if (d[3] !== want.presence_level) begin
                $error("presence_level: expected %0b, actual %0b",
                       want.presence_level, d[3]);
                errors++;
            end
            if (d[11:4] !== want.rx_byte) begin
                $error("rx_byte: expected %h, actual %h", want.rx_byte, d[11:4]);
                errors++;
            end
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [owbm_pkg::IN_DATA_W-1:0]     s_axis_tdata;
    logic [owbm_pkg::IN_USER_W-1:0]     s_axis_tuser;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [owbm_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
    logic                               i_cfg_we;
    logic [owbm_pkg::CFG_IDX_W-1:0]     i_cfg_idx;
    logic [owbm_pkg::CFG_W-1:0]         i_cfg_data;

    onewire_line_model board = new();

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_request;

    onewire_bus_master u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] tx_byte, [8] line_in
        .s_axis_tuser  (s_axis_tuser),   // [1:0] req_type
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [0] line_release, [1] busy_res, [2] done_res,
                                         // [3] presence_level, [11:4] rx_byte
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result side: random back-pressure, plus one long hold on request
    initial begin : result_sink
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else begin
                m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // monitor: predict on every tick transfer, check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                board.take_tick(owbm_pkg::t_req'(s_axis_tuser), s_axis_tdata[7:0],
                                s_axis_tdata[8]);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
        end
    end

    // watchdog on cycles without any transfer
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n && !(s_axis_tvalid && s_axis_tready) &&
                !(m_axis_tvalid && m_axis_tready))
                quiet++;
            else
                quiet = 0;
        end
        $display("FAIL onewire_bus_master");
        $finish;
    end

    // offer one tick and wait for its transfer; entered and left at a falling edge
    task automatic send_tick(owbm_pkg::t_req req, logic [7:0] txb, logic lin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = req;
        s_axis_tdata  = {{(owbm_pkg::IN_DATA_W-9){1'b0}}, lin, txb};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // line level for a whole operation: 0 low, 1 high, otherwise random
    function automatic logic pick_line(int mode);
        if (mode == 0)
            return 1'b0;
        if (mode == 1)
            return 1'b1;
        return 1'($urandom);
    endfunction

    // start an operation and feed ticks until it completes; busy ticks carry noise_req
    task automatic run_op(owbm_pkg::t_req req, logic [7:0] txb, owbm_pkg::t_req noise_req,
                          int line_mode);
        send_tick(req, txb, pick_line(line_mode));
        while (board.in_operation())
            send_tick(noise_req, 8'($urandom), pick_line(line_mode));
    endtask

    // mostly well-formed requests from idle, occasional ignored requests while busy
    task automatic send_random_tick();
        owbm_pkg::t_req req;
        if (!board.in_operation())
            req = ($urandom_range(99) < 70) ? owbm_pkg::t_req'($urandom_range(3, 1))
                                            : owbm_pkg::REQ_TICK;
        else
            req = ($urandom_range(99) < 15) ? owbm_pkg::t_req'($urandom_range(3, 1))
                                            : owbm_pkg::REQ_TICK;
        send_tick(req, 8'($urandom), 1'($urandom));
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (board.pending() != 0)
            @(negedge i_clk);
    endtask

    function automatic t_timing_set timing_set(int rst_low, int pres_wait, int rst_rec,
                                               int wr_low, int wr_hold, int rd_low,
                                               int rd_sample, int rd_rec);
        t_timing_set s;
        s[owbm_pkg::CFG_RESET_LOW]   = owbm_pkg::CFG_W'(rst_low);
        s[owbm_pkg::CFG_PRES_WAIT]   = owbm_pkg::CFG_W'(pres_wait);
        s[owbm_pkg::CFG_RESET_REC]   = owbm_pkg::CFG_W'(rst_rec);
        s[owbm_pkg::CFG_WRITE_LOW]   = owbm_pkg::CFG_W'(wr_low);
        s[owbm_pkg::CFG_WRITE_HOLD]  = owbm_pkg::CFG_W'(wr_hold);
        s[owbm_pkg::CFG_READ_LOW]    = owbm_pkg::CFG_W'(rd_low);
        s[owbm_pkg::CFG_READ_SAMPLE] = owbm_pkg::CFG_W'(rd_sample);
        s[owbm_pkg::CFG_READ_REC]    = owbm_pkg::CFG_W'(rd_rec);
        return s;
    endfunction

    // short phases mostly, now and then a longer one
    function automatic t_timing_set random_timing_set();
        t_timing_set s;
        for (int i = 0; i < owbm_pkg::CFG_NUM; i++)
            s[i] = ($urandom_range(7) == 0) ? owbm_pkg::CFG_W'($urandom_range(LEN_LONG, 4))
                                            : owbm_pkg::CFG_W'($urandom_range(3, 0));
        return s;
    endfunction

    // finish any operation, drain results, then write every timing register
    task automatic load_timing(t_timing_set s);
        while (board.in_operation())
            send_tick(owbm_pkg::REQ_TICK, 8'($urandom), 1'($urandom));
        wait_drained();
        for (int i = 0; i < owbm_pkg::CFG_NUM; i++) begin
            i_cfg_we   = 1'b1;
            i_cfg_idx  = i[owbm_pkg::CFG_IDX_W-1:0];
            i_cfg_data = s[i];
            board.set_timing(i, s[i]);
            @(negedge i_clk);
        end
        i_cfg_we = 1'b0;
    endtask

    // stimulus
    initial begin : stimulus
        t_timing_set s;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = owbm_pkg::REQ_TICK;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        hold_request  = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 52;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // timings after reset: one read, then an idle tick with all data bits set
        run_op(owbm_pkg::REQ_READ, 8'h00, owbm_pkg::REQ_TICK, 2);
        send_tick(owbm_pkg::REQ_TICK, 8'hFF, 1'b1);

        // zero lengths: every operation, both presence answers, busy requests
        load_timing(timing_set(0, 0, 0, 0, 0, 0, 0, 0));
        run_op(owbm_pkg::REQ_RESET, 8'h00, owbm_pkg::REQ_TICK, 0);
        run_op(owbm_pkg::REQ_RESET, 8'h00, owbm_pkg::REQ_READ, 1);
        run_op(owbm_pkg::REQ_WRITE, 8'hFF, owbm_pkg::REQ_RESET, 2);
        run_op(owbm_pkg::REQ_WRITE, 8'h00, owbm_pkg::REQ_WRITE, 2);
        run_op(owbm_pkg::REQ_WRITE, 8'hA5, owbm_pkg::REQ_TICK, 2);
        run_op(owbm_pkg::REQ_READ, 8'h00, owbm_pkg::REQ_WRITE, 1);
        run_op(owbm_pkg::REQ_READ, 8'h00, owbm_pkg::REQ_READ, 0);
        run_op(owbm_pkg::REQ_READ, 8'h5A, owbm_pkg::REQ_TICK, 2);

        // unit lengths, back-to-back operations
        load_timing(timing_set(1, 1, 1, 1, 1, 1, 1, 1));
        run_op(owbm_pkg::REQ_RESET, 8'h00, owbm_pkg::REQ_WRITE, 0);
        run_op(owbm_pkg::REQ_WRITE, 8'h3C, owbm_pkg::REQ_READ, 2);
        run_op(owbm_pkg::REQ_READ, 8'h00, owbm_pkg::REQ_RESET, 2);

        // random phases, each under its own timing setting
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph * 3 / PHASE_COUNT)
                0: begin
                    send_idle_pct = 18;
                    recv_idle_pct = 52;
                end
                1: begin
                    send_idle_pct = 52;
                    recv_idle_pct = 18;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (ph)
                1:  s = timing_set(1, 1, 1, 1, 1, 1, 1, 1);
                3:  s = timing_set(LEN_LONG, LEN_LONG, LEN_LONG, LEN_LONG, 0, 0, LEN_LONG, 0);
                6:  s = timing_set(0, 0, 0, 0, 0, 0, 0, 0);
                9:  s = timing_set(0, 0, 0, 0, LEN_LONG, LEN_LONG, 0, LEN_LONG);
                default: s = random_timing_set();
            endcase
            load_timing(s);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (ph == 4 && n == 20)
                    hold_request = 1'b1;
                if (ph == 7 && n == 10)
                    wait_drained();
                send_random_tick();
            end
        end

        // drain and let the output register settle
        s_axis_tvalid = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("PASS onewire_bus_master");
        else
            $display("FAIL onewire_bus_master");
        $finish;
    end

endmodule

### filelist.f
hdl/owbm_pkg.sv
hdl/owbm_cfg.sv
hdl/onewire_bus_master.sv
tb/tb_onewire_bus_master.sv
